### hdl/cps_pkg.sv
`timescale 1ns / 1ps

package cps_pkg;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_TEXT   = 2'd2;

	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] value;
		logic               last;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] position;
	} out_word_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic clear;
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

### hdl/contiguous_pattern_search.sv
`timescale 1ns / 1ps

// Streaming exact-match search of a loaded word pattern in a word text. Every
// word (clear, pattern append, text) is accepted as it arrives and a result, when
// there is one, appears in the output register on the next cycle; the block
// sustains one word per cycle as long as results are taken. The pattern sits
// in a chain of PATTERN_MAX cells that also holds the text window, so each
// text word is compared against the whole pattern in the cycle it arrives.
// Only the output register limits throughput: a pending result that is not
// taken holds off the input.
module contiguous_pattern_search #(
	parameter int              PATTERN_MAX = 16,
	parameter longint unsigned TEXT_MAX    = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cps_pkg::in_word_t   in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output cps_pkg::out_word_t  out_word
);

	localparam int CW = $clog2(TEXT_MAX + 1);
	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int SW = ((CW > LW) ? CW : LW) + 1;

	logic               accept;
	logic               is_clear, is_append, is_text;
	logic               full;
	cps_pkg::cell_ctl_t ctl;

	logic [31:0]          pat [PATTERN_MAX];
	logic                 act [PATTERN_MAX];
	logic [31:0]          win [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] hit;

	logic [LW-1:0] len_q;
	logic [CW-1:0] cnt_q;
	logic          reported_q;

	logic          in_range;
	logic [SW-1:0] idx_ext, len_ext, start;
	logic          found;
	logic          not_found;
	logic          overflow;

	logic               out_valid_q;
	cps_pkg::out_word_t out_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign is_clear  = accept && (in_word.command == cps_pkg::CMD_CLEAR);
	assign is_append = accept && (in_word.command == cps_pkg::CMD_APPEND);
	assign is_text   = accept && (in_word.command == cps_pkg::CMD_TEXT);

	assign full = act[PATTERN_MAX-1];

	assign ctl.clear = is_clear;
	assign ctl.load  = is_append && !full;
	assign ctl.shift = is_text;

	genvar k;
	generate
		for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
			cps_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.pat_in ((k == 0) ? 32'(in_word.value) : pat[(k == 0) ? 0 : k - 1]),
				.act_in ((k == 0) ? 1'b1 : act[(k == 0) ? 0 : k - 1]),
				.win_in ((k == 0) ? 32'(in_word.value) : win[(k == 0) ? 0 : k - 1]),
				.pat_q  (pat[k]),
				.act_q  (act[k]),
				.win_q  (win[k]),
				.hit    (hit[k])
			);
		end
	endgenerate

	assign in_range = cnt_q < CW'(TEXT_MAX);
	assign idx_ext  = SW'(cnt_q);
	assign len_ext  = SW'(len_q);
	assign start    = idx_ext + SW'(1) - len_ext;

	always_comb begin
		found = 1'b0;
		if (is_text && !reported_q && in_range) begin
			if (len_q == '0) begin
				found = 1'b1;
			end else if ((idx_ext + SW'(1)) >= len_ext) begin
				found = (&hit) && ((start >> 16) == '0);
			end
		end
	end

	assign not_found = is_text && in_word.last && !reported_q && !found;
	assign overflow  = is_append && full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			cnt_q      <= '0;
			reported_q <= 1'b0;
		end else begin
			if (is_clear) begin
				len_q <= '0;
			end else if (is_append && !full) begin
				len_q <= len_q + LW'(1);
			end
			// clear and append both restart the text stream, as does its last word
			if (is_clear || is_append || (is_text && in_word.last)) begin
				cnt_q      <= '0;
				reported_q <= 1'b0;
			end else if (is_text) begin
				if (in_range) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (found) begin
					reported_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (found || not_found || overflow) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (found) begin
			out_q.status   <= cps_pkg::ST_FOUND;
			out_q.position <= (len_q == '0) ? 16'd0 : 16'(start);
		end else if (not_found) begin
			out_q.status   <= cps_pkg::ST_NOT_FOUND;
			out_q.position <= 16'd0;
		end else if (overflow) begin
			out_q.status   <= cps_pkg::ST_OVERFLOW;
			out_q.position <= 16'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

### hdl/cps_cell.sv
`timescale 1ns / 1ps

// One position of the search chain: a pattern word, its active flag and one
// window word. Pattern and window both move one cell up on their own commands.
module cps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  cps_pkg::cell_ctl_t  ctl,
	input  logic [31:0]         pat_in,
	input  logic                act_in,
	input  logic [31:0]         win_in,
	output logic [31:0]         pat_q,
	output logic                act_q,
	output logic [31:0]         win_q,
	output logic                hit
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (ctl.clear) begin
			act_q <= 1'b0;
		end else if (ctl.load) begin
			act_q <= act_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pat_q <= pat_in;
		end
		if (ctl.shift) begin
			win_q <= win_in;
		end
	end

	// compares against the word entering this position on the current shift
	assign hit = !act_q || (win_in == pat_q);

endmodule

### verif/contiguous_pattern_search_test.sv
`timescale 1ns / 1ps

module contiguous_pattern_search_test;
	import cps_pkg::*;

	localparam int PATTERN_MAX = 16;
	localparam int TEXT_MAX = 65536;
	localparam logic [1:0] CMD_RESERVED = 2'd3;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_word;

	contiguous_pattern_search #(
		.PATTERN_MAX(PATTERN_MAX),
		.TEXT_MAX(TEXT_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	in_word_t pending_words[$];
	out_word_t due_results[$];
	int send_idle_pct = 17;
	int recv_idle_pct = 45;
	int mismatches = 0;
	int quiet_cycles = 0;

	// search state mirrored from the block
	logic [31:0] pattern_words [PATTERN_MAX] = '{default: '0};
	int pattern_len = 0;
	logic [31:0] window_words [PATTERN_MAX] = '{default: '0};
	int text_seen = 0;
	bit match_sent = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic restart_stream();
		foreach (window_words[k])
			window_words[k] = '0;
		text_seen = 0;
		match_sent = 1'b0;
	endtask

	task automatic add_due(input logic [1:0] st, input logic [15:0] pos);
		out_word_t r;
		r.status = st;
		r.position = pos;
		due_results.push_back(r);
	endtask

	task automatic search_step(input in_word_t w);
		int idx;
		int k;
		bit equal;
		bit emitted;
		emitted = 1'b0;
		case (w.command)
			CMD_CLEAR: begin
				pattern_len = 0;
				restart_stream();
			end
			CMD_APPEND: begin
				restart_stream();
				if (pattern_len >= PATTERN_MAX)
					add_due(ST_OVERFLOW, '0);
				else begin
					pattern_words[pattern_len] = w.value;
					pattern_len++;
				end
			end
			CMD_TEXT: begin
				idx = text_seen;
				for (k = PATTERN_MAX - 1; k > 0; k--)
					window_words[k] = window_words[k - 1];
				window_words[0] = w.value;
				if (text_seen < TEXT_MAX)
					text_seen++;
				// words past TEXT_MAX still shift but are never searched
				if (!match_sent && idx < TEXT_MAX) begin
					if (pattern_len == 0) begin
						match_sent = 1'b1;
						add_due(ST_FOUND, '0);
						emitted = 1'b1;
					end else if (idx + 1 >= pattern_len) begin
						equal = 1'b1;
						for (k = 0; k < pattern_len; k++)
							if (window_words[pattern_len - 1 - k] != pattern_words[k])
								equal = 1'b0;
						if (equal && idx + 1 - pattern_len <= 32'hffff) begin
							match_sent = 1'b1;
							add_due(ST_FOUND, 16'(idx + 1 - pattern_len));
							emitted = 1'b1;
						end
					end
				end
				if (w.last) begin
					if (!match_sent && !emitted)
						add_due(ST_NOT_FOUND, '0);
					restart_stream();
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic queue_word(input logic [1:0] cmd, input logic [31:0] value,
			input logic last);
		in_word_t w;
		w.command = cmd;
		w.value = value;
		w.last = last;
		pending_words.push_back(w);
	endtask

	function automatic logic [31:0] any_value();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			default: return $urandom();
		endcase
	endfunction

	// Mostly well-formed sessions (clear, appends, a few text streams) over a
	// small alphabet so partial and full matches are common; some noise words.
	task automatic random_sessions(input int quota);
		logic [31:0] pat[$];
		logic [31:0] txt[$];
		logic [31:0] v;
		logic [1:0] cmd;
		int made;
		int plen;
		int tlen;
		int at;
		int i;
		made = 0;
		while (made < quota) begin
			if ($urandom_range(99) < 8) begin
				cmd = 2'($urandom_range(3));
				queue_word(cmd, any_value(), 1'($urandom_range(1)));
				if (cmd != CMD_RESERVED)
					made++;
			end else begin
				queue_word(CMD_CLEAR, any_value(), 1'($urandom_range(1)));
				if ($urandom_range(9) == 0)
					plen = $urandom_range(PATTERN_MAX, PATTERN_MAX + 2);
				else
					plen = $urandom_range(0, 5);
				pat.delete();
				for (i = 0; i < plen; i++) begin
					v = ($urandom_range(3) == 0) ? any_value() : 32'($urandom_range(3));
					queue_word(CMD_APPEND, v, 1'($urandom_range(1)));
					if (pat.size() < PATTERN_MAX)
						pat.push_back(v);
				end
				made += plen + 1;
				repeat ($urandom_range(1, 3)) begin
					tlen = $urandom_range(1, 24);
					txt.delete();
					for (i = 0; i < tlen; i++) begin
						if (pat.size() > 0 && $urandom_range(9) < 6)
							txt.push_back(pat[$urandom_range(pat.size() - 1)]);
						else if ($urandom_range(1))
							txt.push_back(32'($urandom_range(3)));
						else
							txt.push_back(any_value());
					end
					if (pat.size() <= tlen && $urandom_range(1)) begin
						at = $urandom_range(tlen - pat.size());
						for (i = 0; i < pat.size(); i++)
							txt[at + i] = pat[i];
						// near miss: flip one bit inside the planted copy
						if (pat.size() > 0 && $urandom_range(3) == 0) begin
							i = at + $urandom_range(pat.size() - 1);
							txt[i] = txt[i] ^ (32'h1 << $urandom_range(31));
						end
					end
					// now and then a stream is left open and runs on into the words that follow
					for (i = 0; i < tlen; i++)
						queue_word(CMD_TEXT, txt[i],
							i == tlen - 1 && $urandom_range(9) != 0);
					made += tlen;
				end
			end
		end
	endtask

	task automatic wait_idle();
		while (pending_words.size() > 0 || in_valid || due_results.size() > 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			in_valid <= 1'b0;
		else if (!in_valid || in_ready) begin
			if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_word <= pending_words.pop_front();
			end else
				in_valid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		out_word_t due;
		if (arst_n) begin
			// predict first so a same-edge result still finds its expectation
			if (in_valid && in_ready)
				search_step(in_word);
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result word: status %0d position %0d",
							out_word.status, out_word.position);
					mismatches++;
				end else begin
					due = due_results.pop_front();
					if (out_word.status !== due.status
							|| out_word.position !== due.position) begin
						if (mismatches < 10)
							$display("mismatch: status exp %0d got %0d, position exp %0d got %0d",
								due.status, out_word.status, due.position, out_word.position);
						mismatches++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("contiguous_pattern_search_test: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int n;
		// empty pattern matches at 0 on the first text word, rest is silent
		queue_word(CMD_TEXT, 32'h0000_0005, 1'b0);
		queue_word(CMD_TEXT, 32'h8000_0000, 1'b1);
		queue_word(CMD_RESERVED, 32'hffff_ffff, 1'b1);
		queue_word(CMD_APPEND, 32'h7fff_ffff, 1'b0);
		queue_word(CMD_APPEND, 32'h8000_0000, 1'b1);
		// match completes on the last word, start index 1
		queue_word(CMD_TEXT, 32'h0000_0001, 1'b0);
		queue_word(CMD_TEXT, 32'h7fff_ffff, 1'b0);
		queue_word(CMD_TEXT, 32'h8000_0000, 1'b1);
		queue_word(CMD_TEXT, 32'h8000_0000, 1'b0);
		queue_word(CMD_TEXT, 32'h7fff_ffff, 1'b1);
		// fill the store, then one more append overflows
		for (n = 0; n < PATTERN_MAX - 1; n++)
			queue_word(CMD_APPEND, ~32'(n), 1'b0);
		queue_word(CMD_CLEAR, 32'hffff_ffff, 1'b1);
		random_sessions(420);
		wait_idle();

		send_idle_pct = 45;
		recv_idle_pct = 17;
		random_sessions(420);
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_sessions(410);
		wait_idle();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("contiguous_pattern_search_test: done, clean");
		else
			$display("contiguous_pattern_search_test: done, errors");
		$finish;
	end

endmodule
